// ===== rtl/ttuv_pkg.sv =====
`timescale 1ns / 1ps

package ttuv_pkg;

    // Fixed-point format of positions, texture coordinates and tangents
    localparam int FRAC_BITS = 16;
    localparam int VW = 32;                 // field width
    localparam int DW = VW + 1;             // edge or UV delta
    localparam int PW = 2 * DW;             // signed product of two deltas
    localparam int SW = PW + 2;             // shared subtractor width
    localparam int MW = PW;                 // magnitude of a product difference
    localparam int XW = MW + FRAC_BITS;     // scaled dividend
    localparam int QW = VW;                 // quotient bits produced by the divider
    localparam int HW = XW - QW;            // dividend bits above the quotient bits
    localparam int CW = $clog2(QW);         // divider step counter

    localparam logic [VW-1:0] SAT_POS = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] SAT_NEG = {1'b1, {(VW-1){1'b0}}};

    typedef struct packed {
        logic signed [VW-1:0] pos_x;
        logic signed [VW-1:0] pos_y;
        logic signed [VW-1:0] pos_z;
        logic signed [VW-1:0] tex_u;
        logic signed [VW-1:0] tex_v;
    } vertex_t;

    typedef struct packed {
        logic signed [VW-1:0] tangent_x;
        logic signed [VW-1:0] tangent_y;
        logic signed [VW-1:0] tangent_z;
        logic                 degenerate;
        logic                 clipped;
    } tangent_t;

    // Edge vectors and UV deltas of one triangle
    typedef struct packed {
        logic signed [DW-1:0] e1_x;
        logic signed [DW-1:0] e1_y;
        logic signed [DW-1:0] e1_z;
        logic signed [DW-1:0] e2_x;
        logic signed [DW-1:0] e2_y;
        logic signed [DW-1:0] e2_z;
        logic signed [DW-1:0] du1;
        logic signed [DW-1:0] dv1;
        logic signed [DW-1:0] du2;
        logic signed [DW-1:0] dv2;
    } delta_t;

    typedef struct packed {
        logic start;
        logic take;
    } ctrl_t;

    typedef struct packed {
        logic busy;
        logic res_valid;
    } stat_t;

endpackage

// ===== rtl/ttuv_core.sv =====
`timescale 1ns / 1ps

module ttuv_core (
    input  logic              clk,
    input  logic              rst_n,
    input  ttuv_pkg::ctrl_t   ctrl,
    input  ttuv_pkg::delta_t  delta,
    output ttuv_pkg::stat_t   stat,
    output ttuv_pkg::tangent_t result
);
    import ttuv_pkg::*;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DET_A    = 4'd1;
    localparam logic [3:0] ST_DET_B    = 4'd2;
    localparam logic [3:0] ST_DET_S    = 4'd3;
    localparam logic [3:0] ST_DET_M    = 4'd4;
    localparam logic [3:0] ST_NUM_A    = 4'd5;
    localparam logic [3:0] ST_NUM_B    = 4'd6;
    localparam logic [3:0] ST_NUM_S    = 4'd7;
    localparam logic [3:0] ST_NUM_M    = 4'd8;
    localparam logic [3:0] ST_DIV_INIT = 4'd9;
    localparam logic [3:0] ST_DIV      = 4'd10;
    localparam logic [3:0] ST_ROUND    = 4'd11;
    localparam logic [3:0] ST_DONE     = 4'd12;

    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    localparam logic [CW-1:0] CNT_LAST = CW'(QW - 1);

    logic [3:0]           state_reg, state_next;
    logic [1:0]           comp_reg, comp_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    delta_t               delta_reg, delta_next;
    logic signed [PW-1:0] mul_reg, first_reg;
    logic [SW-1:0]        acc_reg, acc_next;
    logic [MW-1:0]        det_mag_reg, det_mag_next;
    logic                 det_neg_reg, det_neg_next;
    logic [MW-1:0]        num_mag_reg, num_mag_next;
    logic                 num_neg_reg, num_neg_next;
    logic [MW-1:0]        rem_reg, rem_next;
    logic [QW-1:0]        qsh_reg, qsh_next;
    logic [VW-1:0]        tan_reg [3];
    logic [VW-1:0]        tan_next [3];
    logic                 degen_reg, degen_next;
    logic                 clip_reg, clip_next;

    logic signed [DW-1:0] mul_a, mul_b, e1_sel, e2_sel;
    logic signed [PW-1:0] mul_p;
    logic [SW-1:0]        sub_a, sub_b, sub_d;
    logic                 borrow;
    logic [XW-1:0]        x_full;
    logic [HW-1:0]        x_hi;
    logic [QW-1:0]        x_lo;
    logic                 res_neg;
    logic [QW:0]          qr, qr_neg;

    // Select the edge components of the current tangent component
    always_comb
    begin
        case (comp_reg)
            COMP_X:
            begin
                e1_sel = delta_reg.e1_x;
                e2_sel = delta_reg.e2_x;
            end
            COMP_Y:
            begin
                e1_sel = delta_reg.e1_y;
                e2_sel = delta_reg.e2_y;
            end
            default:
            begin
                e1_sel = delta_reg.e1_z;
                e2_sel = delta_reg.e2_z;
            end
        endcase
    end

    // Shared multiplier operands
    always_comb
    begin
        case (state_reg)
            ST_DET_A:
            begin
                mul_a = delta_reg.du1;
                mul_b = delta_reg.dv2;
            end
            ST_DET_B:
            begin
                mul_a = delta_reg.du2;
                mul_b = delta_reg.dv1;
            end
            ST_NUM_A:
            begin
                mul_a = delta_reg.dv2;
                mul_b = e1_sel;
            end
            ST_NUM_B:
            begin
                mul_a = delta_reg.dv1;
                mul_b = e2_sel;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Scaled dividend split into the initial remainder and the bits shifted in
    assign x_full  = {num_mag_reg, {FRAC_BITS{1'b0}}};
    assign x_hi    = x_full[XW-1:QW];
    assign x_lo    = x_full[QW-1:0];
    assign res_neg = num_neg_reg ^ det_neg_reg;

    // Shared subtractor operands
    always_comb
    begin
        case (state_reg)
            ST_DET_S, ST_NUM_S:
            begin
                sub_a = {{2{first_reg[PW-1]}}, first_reg};
                sub_b = {{2{mul_reg[PW-1]}}, mul_reg};
            end
            ST_DET_M, ST_NUM_M:
            begin
                sub_a = acc_reg[SW-1] ? '0 : acc_reg;
                sub_b = acc_reg[SW-1] ? acc_reg : '0;
            end
            ST_DIV_INIT:
            begin
                sub_a = {{(SW-HW){1'b0}}, x_hi};
                sub_b = {{(SW-MW){1'b0}}, det_mag_reg};
            end
            ST_DIV:
            begin
                sub_a = {1'b0, rem_reg, qsh_reg[QW-1]};
                sub_b = {{(SW-MW){1'b0}}, det_mag_reg};
            end
            ST_ROUND:
            begin
                sub_a = {1'b0, rem_reg, 1'b0};
                sub_b = {{(SW-MW){1'b0}}, det_mag_reg};
            end
            default:
            begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
    end

    assign sub_d  = sub_a - sub_b;
    assign borrow = sub_d[SW-1];

    // Round the quotient magnitude, half away from zero
    assign qr     = {1'b0, qsh_reg} + {{QW{1'b0}}, ~borrow};
    assign qr_neg = ~qr + {{QW{1'b0}}, 1'b1};

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        comp_next    = comp_reg;
        cnt_next     = cnt_reg;
        delta_next   = delta_reg;
        acc_next     = acc_reg;
        det_mag_next = det_mag_reg;
        det_neg_next = det_neg_reg;
        num_mag_next = num_mag_reg;
        num_neg_next = num_neg_reg;
        rem_next     = rem_reg;
        qsh_next     = qsh_reg;
        tan_next     = tan_reg;
        degen_next   = degen_reg;
        clip_next    = clip_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (ctrl.start)
                begin
                    delta_next = delta;
                    degen_next = 1'b0;
                    clip_next  = 1'b0;
                    comp_next  = COMP_X;
                    state_next = ST_DET_A;
                end
            end
            ST_DET_A:
            begin
                state_next = ST_DET_B;
            end
            ST_DET_B:
            begin
                state_next = ST_DET_S;
            end
            ST_DET_S:
            begin
                acc_next   = sub_d;
                state_next = ST_DET_M;
            end
            ST_DET_M:
            begin
                det_mag_next = sub_d[MW-1:0];
                det_neg_next = acc_reg[SW-1];
                if (acc_reg == '0)
                begin
                    tan_next[0] = '0;
                    tan_next[1] = '0;
                    tan_next[2] = '0;
                    degen_next  = 1'b1;
                    state_next  = ST_DONE;
                end
                else
                begin
                    state_next = ST_NUM_A;
                end
            end
            ST_NUM_A:
            begin
                state_next = ST_NUM_B;
            end
            ST_NUM_B:
            begin
                state_next = ST_NUM_S;
            end
            ST_NUM_S:
            begin
                acc_next   = sub_d;
                state_next = ST_NUM_M;
            end
            ST_NUM_M:
            begin
                num_mag_next = sub_d[MW-1:0];
                num_neg_next = acc_reg[SW-1];
                state_next   = ST_DIV_INIT;
            end
            ST_DIV_INIT:
            begin
                if (!borrow)
                begin
                    // quotient needs more than the result width: saturate
                    tan_next[comp_reg] = res_neg ? SAT_NEG : SAT_POS;
                    clip_next          = 1'b1;
                    if (comp_reg == COMP_Z)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = ST_NUM_A;
                    end
                end
                else
                begin
                    rem_next   = {{(MW-HW){1'b0}}, x_hi};
                    qsh_next   = x_lo;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!borrow)
                begin
                    rem_next = sub_d[MW-1:0];
                end
                else
                begin
                    rem_next = {rem_reg[MW-2:0], qsh_reg[QW-1]};
                end
                qsh_next = {qsh_reg[QW-2:0], ~borrow};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (res_neg)
                begin
                    if (qr > {1'b0, SAT_NEG})
                    begin
                        tan_next[comp_reg] = SAT_NEG;
                        clip_next          = 1'b1;
                    end
                    else
                    begin
                        tan_next[comp_reg] = qr_neg[VW-1:0];
                    end
                end
                else
                begin
                    if (qr > {1'b0, SAT_POS})
                    begin
                        tan_next[comp_reg] = SAT_POS;
                        clip_next          = 1'b1;
                    end
                    else
                    begin
                        tan_next[comp_reg] = qr[VW-1:0];
                    end
                end
                if (comp_reg == COMP_Z)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = ST_NUM_A;
                end
            end
            ST_DONE:
            begin
                if (ctrl.take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance the datapath registers
    always_ff @(posedge clk)
    begin
        mul_reg     <= mul_p;
        first_reg   <= mul_reg;
        comp_reg    <= comp_next;
        cnt_reg     <= cnt_next;
        delta_reg   <= delta_next;
        acc_reg     <= acc_next;
        det_mag_reg <= det_mag_next;
        det_neg_reg <= det_neg_next;
        num_mag_reg <= num_mag_next;
        num_neg_reg <= num_neg_next;
        rem_reg     <= rem_next;
        qsh_reg     <= qsh_next;
        tan_reg     <= tan_next;
        degen_reg   <= degen_next;
        clip_reg    <= clip_next;
    end

    assign stat.busy         = (state_reg != ST_IDLE);
    assign stat.res_valid    = (state_reg == ST_DONE);
    assign result.tangent_x  = tan_reg[0];
    assign result.tangent_y  = tan_reg[1];
    assign result.tangent_z  = tan_reg[2];
    assign result.degenerate = degen_reg;
    assign result.clipped    = clip_reg;

    // The partial remainder stays below the divisor throughout the division
    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> rem_reg < det_mag_reg)
        else $error("divider remainder not below divisor");

    // The divider runs its full count of steps
    a_div_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && cnt_reg != CNT_LAST) |=> state_reg == ST_DIV)
        else $error("divider left early");

    // A finished result waits unchanged until taken
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.res_valid && !ctrl.take) |=> (stat.res_valid && $stable(result)))
        else $error("result dropped or changed before take");

    // A degenerate triangle gives a zero, unclipped tangent
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.res_valid && result.degenerate) |->
        (result.tangent_x == '0 && result.tangent_y == '0 &&
         result.tangent_z == '0 && !result.clipped))
        else $error("degenerate result not zero");

endmodule

// ===== rtl/triangle_tangent_from_uv.sv =====
`timescale 1ns / 1ps

// Channel  Payload    Handshake             Transaction
// vtx      vertex_t   vtx_valid, vtx_stall  one triangle vertex, three per triangle
// tan      tangent_t  tan_valid, tan_stall  one tangent per completed triangle
//
// First and second vertex of a triangle: each is taken and held in a register.
// Third vertex: starts the sequencer, which forms the determinant, then per component
// the numerator and the quotient, and loads the tangent into the output register; a
// saturated component skips the division, a degenerate triangle ends after the
// determinant. A restoring divider, one quotient bit per cycle, serves the three components.
// vtx_stall is high while the sequencer works on a triangle or holds its result.
// Reset clears the vertex phase, the sequencer and the output valid.
// A stalled tan transaction holds, and a further finished result waits in the core.

module triangle_tangent_from_uv (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               vtx_valid,
    output logic               vtx_stall,
    input  ttuv_pkg::vertex_t  vtx,
    output logic               tan_valid,
    input  logic               tan_stall,
    output ttuv_pkg::tangent_t tan
);
    import ttuv_pkg::*;

    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_THIRD  = 2'd2;

    logic [1:0] phase_reg, phase_next;
    vertex_t    v0_reg, v1_reg;
    logic       tan_valid_reg, tan_valid_next;
    tangent_t   tan_reg;
    logic       accept;
    ctrl_t      ctrl;
    stat_t      stat;
    delta_t     delta;
    tangent_t   core_res;

    // Exact difference of two fields, one bit wider
    function automatic logic [DW-1:0] sdelta(input logic [VW-1:0] a, input logic [VW-1:0] b);
        sdelta = {a[VW-1], a} - {b[VW-1], b};
    endfunction

    assign accept    = vtx_valid && !vtx_stall;
    assign vtx_stall = stat.busy;

    // Form edges against vertex 0 from the held vertices and the incoming one
    assign delta.e1_x = sdelta(v1_reg.pos_x, v0_reg.pos_x);
    assign delta.e1_y = sdelta(v1_reg.pos_y, v0_reg.pos_y);
    assign delta.e1_z = sdelta(v1_reg.pos_z, v0_reg.pos_z);
    assign delta.e2_x = sdelta(vtx.pos_x, v0_reg.pos_x);
    assign delta.e2_y = sdelta(vtx.pos_y, v0_reg.pos_y);
    assign delta.e2_z = sdelta(vtx.pos_z, v0_reg.pos_z);
    assign delta.du1  = sdelta(v1_reg.tex_u, v0_reg.tex_u);
    assign delta.dv1  = sdelta(v1_reg.tex_v, v0_reg.tex_v);
    assign delta.du2  = sdelta(vtx.tex_u, v0_reg.tex_u);
    assign delta.dv2  = sdelta(vtx.tex_v, v0_reg.tex_v);

    assign ctrl.start = accept && (phase_reg == PH_THIRD);
    assign ctrl.take  = stat.res_valid && (!tan_valid_reg || !tan_stall);

    ttuv_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .delta  (delta),
        .stat   (stat),
        .result (core_res)
    );

    // Advance the vertex phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_SECOND: phase_next = PH_THIRD;
                PH_THIRD:  phase_next = PH_FIRST;
                default:   phase_next = PH_SECOND;
            endcase
        end
    end

    // Drop the output transaction once taken, load a new one from the core
    always_comb
    begin
        tan_valid_next = tan_valid_reg;
        if (ctrl.take)
        begin
            tan_valid_next = 1'b1;
        end
        else if (!tan_stall)
        begin
            tan_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FIRST;
            tan_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            tan_valid_reg <= tan_valid_next;
        end
    end

    // Hold the first two vertices and the output payload
    always_ff @(posedge clk)
    begin
        if (accept && phase_reg == PH_SECOND)
        begin
            v1_reg <= vtx;
        end
        else if (accept && phase_reg != PH_THIRD)
        begin
            v0_reg <= vtx;
        end
        if (ctrl.take)
        begin
            tan_reg <= core_res;
        end
    end

    assign tan_valid = tan_valid_reg;
    assign tan       = tan_reg;

    // The third vertex of a triangle blocks the input while the core works
    a_third_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == PH_THIRD) |=> vtx_stall)
        else $error("input not stalled after third vertex");

    // A result taken from the core shows up at the output
    a_take_shows: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.take |=> tan_valid_reg)
        else $error("taken result not presented");

    // The core keeps its result while the output register is blocked
    a_core_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.res_valid && tan_valid_reg && tan_stall) |=> stat.res_valid)
        else $error("core result lost while output blocked");

endmodule
